// ===== rtl/ccld_pkg.sv =====
// Shared types, constants and helpers for the character canvas line drawer.
package ccld_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int COORD_W  = 6;
   localparam int DIM_W    = 7;
   localparam int CNT_W    = COORD_W + 1;

   typedef enum logic [1:0] {
      REQ_DRAW  = 2'd0,
      REQ_ERASE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_REJECT = 2'd1,
      STAT_IGNORE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SYM_BLANK     = 3'd0,
      SYM_HYPHEN    = 3'd1,
      SYM_BAR       = 3'd2,
      SYM_SLASH     = 3'd3,
      SYM_BACKSLASH = 3'd4,
      SYM_PLUS      = 3'd5
   } sym_type;

   typedef enum logic {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_WALK
   } state_type;

   typedef struct packed {
      kind_type             req_type;
      logic [COORD_W-1:0]   first_row;
      logic [COORD_W-1:0]   first_col;
      logic [COORD_W-1:0]   end_row;
      logic [COORD_W-1:0]   end_col;
   } req_type;

   typedef struct packed {
      status_type status;
      sym_type    cell_code;
   } rsp_type;

   // Decoded command: outcome, symbol and walk setup.
   typedef struct packed {
      status_type          status;
      sym_type             sym;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   step;
      logic [CNT_W-1:0]    count;
   } plan_type;

   function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] r,
                                                   logic [COORD_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
   endfunction

   function automatic sym_type stamp_sym(sym_type old, sym_type sym);
      return (old == SYM_BLANK || old == sym) ? sym : SYM_PLUS;
   endfunction

endpackage

// ===== rtl/ccld_decode.sv =====
// Request decoder: bounds checks, line classification and walk setup.
module ccld_decode import ccld_pkg::*; (
   input  req_type               req,
   input  logic [DIM_W-1:0]      rows,
   input  logic [DIM_W-1:0]      cols,
   output plan_type              plan
);

   logic [DIM_W-1:0]        eff_rows;
   logic [DIM_W-1:0]        eff_cols;
   logic                    s_ok;
   logic                    e_ok;
   logic signed [DIM_W-1:0] dr;
   logic signed [DIM_W-1:0] dc;
   logic [DIM_W-1:0]        adr;
   logic [DIM_W-1:0]        adc;
   logic [ADDR_W-1:0]       row_step;
   logic [ADDR_W-1:0]       col_step;
   logic                    is_line;
   sym_type                 line_sym;

   always_comb begin
      // saturate the bounds into 1..max
      if (rows == '0) begin
         eff_rows = DIM_W'(1);
      end else if (rows > DIM_W'(MAX_ROWS)) begin
         eff_rows = DIM_W'(MAX_ROWS);
      end else begin
         eff_rows = rows;
      end
      if (cols == '0) begin
         eff_cols = DIM_W'(1);
      end else if (cols > DIM_W'(MAX_COLS)) begin
         eff_cols = DIM_W'(MAX_COLS);
      end else begin
         eff_cols = cols;
      end
   end

   assign s_ok = (DIM_W'(req.first_row) < eff_rows) && (DIM_W'(req.first_col) < eff_cols);
   assign e_ok = (DIM_W'(req.end_row) < eff_rows) && (DIM_W'(req.end_col) < eff_cols);

   assign dr  = $signed(DIM_W'(req.end_row)) - $signed(DIM_W'(req.first_row));
   assign dc  = $signed(DIM_W'(req.end_col)) - $signed(DIM_W'(req.first_col));
   assign adr = (dr < 0) ? DIM_W'(-dr) : DIM_W'(dr);
   assign adc = (dc < 0) ? DIM_W'(-dc) : DIM_W'(dc);

   always_comb begin
      is_line  = 1'b1;
      line_sym = SYM_HYPHEN;
      if (dr == 0) begin
         line_sym = SYM_HYPHEN;
      end else if (dc == 0) begin
         line_sym = SYM_BAR;
      end else if (dr == -dc) begin
         line_sym = SYM_BACKSLASH;
      end else if (dr == dc) begin
         line_sym = SYM_SLASH;
      end else begin
         is_line = 1'b0;
      end
   end

   // address steps wrap modulo the address width
   always_comb begin
      if (dr > 0) begin
         row_step = ADDR_W'(MAX_COLS);
      end else if (dr < 0) begin
         row_step = ADDR_W'(0) - ADDR_W'(MAX_COLS);
      end else begin
         row_step = '0;
      end
      if (dc > 0) begin
         col_step = ADDR_W'(1);
      end else if (dc < 0) begin
         col_step = '1;
      end else begin
         col_step = '0;
      end
   end

   always_comb begin
      plan.sym   = line_sym;
      plan.addr  = cell_addr(req.first_row, req.first_col);
      plan.step  = ADDR_W'(row_step + col_step);
      plan.count = (adr != '0) ? CNT_W'(adr + DIM_W'(1)) : CNT_W'(adc + DIM_W'(1));
      case (req.req_type)
         REQ_DRAW: begin
            if (!s_ok || !e_ok || (dr == 0 && dc == 0)) begin
               plan.status = STAT_REJECT;
            end else if (!is_line) begin
               plan.status = STAT_IGNORE;
            end else begin
               plan.status = STAT_DONE;
            end
         end
         REQ_ERASE, REQ_READ: begin
            plan.status = s_ok ? STAT_DONE : STAT_REJECT;
         end
         REQ_CLEAR: begin
            plan.status = STAT_DONE;
         end
         default: begin
            plan.status = STAT_DONE;
         end
      endcase
   end

endmodule

// ===== rtl/char_canvas_line_drawer_top.sv =====
// A draw walks its cells and its result appears as it returns to idle, when the next
// request can already be taken; a read answers after S_READ, erase and rejects from idle.
// Clear sweeps all 4096 cell memory entries one entry a cycle, then gives the result.
// The draw walk is set by the single memory: one read and one write per cycle.
// Reset is synchronous; afterwards busy stays high for a full clear pass.
// Results are single-cycle strobes; the receiver cannot stall.
module char_canvas_line_drawer_top import ccld_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   state_type            state_ff, state_in;
   logic [DIM_W-1:0]     rows_ff, rows_in;
   logic [DIM_W-1:0]     cols_ff, cols_in;
   logic [ADDR_W-1:0]    clr_idx_ff, clr_idx_in;
   logic                 clr_reply_ff, clr_reply_in;
   logic [ADDR_W-1:0]    cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   sym_type              sym_ff, sym_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 clr_last;
   plan_type             plan;

   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   sym_type              mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   sym_type              rd_data_ff;
   sym_type              mem [DEPTH];

   ccld_decode u_decode (
      .req  (req_data),
      .rows (rows_ff),
      .cols (cols_ff),
      .plan (plan)
   );

   assign accept   = start && (state_ff == S_IDLE);
   assign clr_last = (clr_idx_ff == ADDR_W'(DEPTH - 1));
   assign busy     = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_DRAW: begin
                     if (plan.status == STAT_DONE) begin
                        state_in = S_WALK;
                     end
                  end
                  REQ_READ: begin
                     if (plan.status == STAT_DONE) begin
                        state_in = S_READ;
                     end
                  end
                  REQ_CLEAR: state_in = S_CLEAR;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            if (clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_READ: state_in = S_IDLE;
         S_WALK: begin
            if (left_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      clr_idx_in   = clr_idx_ff;
      clr_reply_in = clr_reply_ff;
      cur_addr_in  = cur_addr_ff;
      step_in      = step_ff;
      left_in      = left_ff;
      sym_in       = sym_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = plan.addr;
      mem_wdata    = SYM_BLANK;
      mem_re       = 1'b0;
      mem_raddr    = plan.addr;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_data_in.status    = plan.status;
               rsp_data_in.cell_code = SYM_BLANK;
               case (req_data.req_type)
                  REQ_DRAW: begin
                     if (plan.status == STAT_DONE) begin
                        cur_addr_in = plan.addr;
                        step_in     = plan.step;
                        left_in     = plan.count;
                        sym_in      = plan.sym;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  REQ_ERASE: begin
                     mem_we       = (plan.status == STAT_DONE);
                     rsp_valid_in = 1'b1;
                  end
                  REQ_READ: begin
                     mem_re       = (plan.status == STAT_DONE);
                     rsp_valid_in = (plan.status != STAT_DONE);
                  end
                  REQ_CLEAR: begin
                     clr_idx_in   = '0;
                     clr_reply_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = ADDR_W'(clr_idx_ff + ADDR_W'(1));
            if (clr_last) begin
               rsp_valid_in          = clr_reply_ff;
               rsp_data_in.status    = STAT_DONE;
               rsp_data_in.cell_code = SYM_BLANK;
            end
         end
         S_READ: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.status    = STAT_DONE;
            rsp_data_in.cell_code = rd_data_ff;
         end
         S_WALK: begin
            // read the next cell while the previous one is written back
            if (left_ff != '0) begin
               mem_re       = 1'b1;
               mem_raddr    = cur_addr_ff;
               cur_addr_in  = ADDR_W'(cur_addr_ff + step_ff);
               left_in      = CNT_W'(left_ff - CNT_W'(1));
               pend_in      = 1'b1;
               pend_addr_in = cur_addr_ff;
            end else begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = STAT_DONE;
               rsp_data_in.cell_code = SYM_BLANK;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = stamp_sym(rd_data_ff, sym_ff);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rows_ff      <= DIM_W'(MAX_ROWS);
         cols_ff      <= DIM_W'(MAX_COLS);
         clr_idx_ff   <= '0;
         clr_reply_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         clr_idx_ff   <= clr_idx_in;
         clr_reply_ff <= clr_reply_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_addr_ff  <= cur_addr_in;
      step_ff      <= step_in;
      left_ff      <= left_in;
      sym_ff       <= sym_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

`ifndef ASSERT_OFF
   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !clr_last) |=> (state_ff == S_CLEAR))
      else $error("clear sweep left early");

   a_read_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (rsp_valid && rsp_data.status == STAT_DONE))
      else $error("read produced no result");

   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && state_in == S_IDLE) |-> (pend_ff && rsp_valid_in))
      else $error("walk ended without final write and result");

   a_draw_enters_walk: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == REQ_DRAW && plan.status == STAT_DONE)
      |=> (state_ff == S_WALK && !rsp_valid))
      else $error("accepted draw did not start walking");
`endif

endmodule

// ===== tb/canvas_checker.sv =====
// Checker for the canvas line drawer: shadow grid, expected-result queue and field compare.
`timescale 1ns / 1ps
module canvas_checker import ccld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [DIM_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               checked
);

   sym_type          shadow_cells [DEPTH];
   logic [DIM_W-1:0] rows_reg;
   logic [DIM_W-1:0] cols_reg;
   rsp_type          want_rsp [$];
   int               mismatches = 0;
   int               compared = 0;

   // Zero reads as one row or column; anything past the grid saturates.
   function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic bit on_canvas(int r, int c);
      return r < clamp_dim(rows_reg, MAX_ROWS) && c < clamp_dim(cols_reg, MAX_COLS);
   endfunction

   function automatic void wipe_cells();
      for (int i = 0; i < DEPTH; i++) shadow_cells[ADDR_W'(i)] = SYM_BLANK;
   endfunction

   // Apply one request to the shadow grid and return the result it must produce.
   function automatic rsp_type apply_request(req_type q);
      rsp_type res;
      sym_type mark;
      int      sr, sc, er, ec, dr, dc, n, r, c, step_r, step_c, idx, k;
      sr = int'(q.first_row);
      sc = int'(q.first_col);
      er = int'(q.end_row);
      ec = int'(q.end_col);
      res.status = STAT_DONE;
      res.cell_code = SYM_BLANK;
      mark = SYM_BLANK;
      case (q.req_type)
         REQ_DRAW: begin
            if (!on_canvas(sr, sc) || !on_canvas(er, ec) || (sr == er && sc == ec)) begin
               res.status = STAT_REJECT;
            end else begin
               dr = er - sr;
               dc = ec - sc;
               if (dr == 0) mark = SYM_HYPHEN;
               else if (dc == 0) mark = SYM_BAR;
               else if (dr == -dc) mark = SYM_BACKSLASH;
               else if (dr == dc) mark = SYM_SLASH;
               else res.status = STAT_IGNORE;
               if (res.status == STAT_DONE) begin
                  n = (dr != 0) ? ((dr < 0) ? -dr : dr) : ((dc < 0) ? -dc : dc);
                  step_r = (dr > 0) ? 1 : ((dr < 0) ? -1 : 0);
                  step_c = (dc > 0) ? 1 : ((dc < 0) ? -1 : 0);
                  r = sr;
                  c = sc;
                  for (k = 0; k <= n; k++) begin
                     idx = r * MAX_COLS + c;
                     // a crossing with a different symbol turns into plus
                     if (shadow_cells[ADDR_W'(idx)] == SYM_BLANK ||
                         shadow_cells[ADDR_W'(idx)] == mark)
                        shadow_cells[ADDR_W'(idx)] = mark;
                     else
                        shadow_cells[ADDR_W'(idx)] = SYM_PLUS;
                     r += step_r;
                     c += step_c;
                  end
               end
            end
         end
         REQ_ERASE: begin
            if (on_canvas(sr, sc)) shadow_cells[ADDR_W'(sr * MAX_COLS + sc)] = SYM_BLANK;
            else res.status = STAT_REJECT;
         end
         REQ_READ: begin
            if (on_canvas(sr, sc)) res.cell_code = shadow_cells[ADDR_W'(sr * MAX_COLS + sc)];
            else res.status = STAT_REJECT;
         end
         default: begin
            wipe_cells();
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wipe_cells();
         rows_reg = DIM_W'(MAX_ROWS);
         cols_reg = DIM_W'(MAX_COLS);
         want_rsp.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ROWS) rows_reg = csr_wdata;
            else cols_reg = csr_wdata;
         end
         if (rsp_valid) begin
            if (want_rsp.size() == 0) begin
               $error("unexpected result: status %0d, cell_code %0d",
                      rsp_data.status, rsp_data.cell_code);
               mismatches++;
            end else begin
               want = want_rsp.pop_front();
               compared++;
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.cell_code !== want.cell_code) begin
                  $error("cell_code: expected %0d, got %0d",
                         want.cell_code, rsp_data.cell_code);
                  mismatches++;
               end
            end
         end
         // predict on the transfer; the grid moves in request order
         if (start && !busy) want_rsp.push_back(apply_request(req_data));
      end
      pending    <= want_rsp.size();
      fail_count <= mismatches;
      checked    <= compared;
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the canvas line drawer: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
   import ccld_pkg::*;

   localparam int ITEMS_PER_PHASE = 65;
   localparam int PHASES          = 10;
   localparam int CLEAR_BUDGET    = 16;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int DRAIN_CYCLES    = 80;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_we = 1'b0;
   csr_index_type    csr_index = CSR_ROWS;
   logic [DIM_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int checked;

   int cycles = 0;
   int rows_eff = MAX_ROWS;
   int cols_eff = MAX_COLS;
   int last_sr = 0, last_sc = 0, last_er = 0, last_ec = 0;
   int clears_left = CLEAR_BUDGET;
   int sent = 0;
   int clears_sent = 0;
   int settings_used = 1;
   int stretch_left = 0;
   bit idle_on = 1'b0;

   char_canvas_line_drawer_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   canvas_checker chk (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic int pick(int span);
      return $urandom_range(span - 1, 0);
   endfunction

   function automatic req_type mk(kind_type kind, int sr, int sc, int er, int ec);
      req_type q;
      q.req_type  = kind;
      q.first_row = COORD_W'(sr);
      q.first_col = COORD_W'(sc);
      q.end_row   = COORD_W'(er);
      q.end_col   = COORD_W'(ec);
      return q;
   endfunction

   // Line inside the current canvas, in one of the four directions (a single point when there is no room).
   function automatic req_type make_line();
      int sr, sc, er, ec, room_r, room_c, n, dir_r, dir_c;
      sr = pick(rows_eff);
      sc = pick(cols_eff);
      er = sr;
      ec = sc;
      case ($urandom_range(3, 0))
         0: begin
            if (cols_eff > 1) ec = (sc + $urandom_range(cols_eff - 1, 1)) % cols_eff;
         end
         1: begin
            if (rows_eff > 1) er = (sr + $urandom_range(rows_eff - 1, 1)) % rows_eff;
         end
         default: begin
            dir_r = (sr == 0) ? 1 : (sr == rows_eff - 1) ? -1 : ($urandom_range(1, 0) ? 1 : -1);
            dir_c = (sc == 0) ? 1 : (sc == cols_eff - 1) ? -1 : ($urandom_range(1, 0) ? 1 : -1);
            room_r = (dir_r > 0) ? rows_eff - 1 - sr : sr;
            room_c = (dir_c > 0) ? cols_eff - 1 - sc : sc;
            n = (room_r < room_c) ? room_r : room_c;
            if (n > 0) n = $urandom_range(n, 1);
            er = sr + dir_r * n;
            ec = sc + dir_c * n;
         end
      endcase
      last_sr = sr;
      last_sc = sc;
      last_er = er;
      last_ec = ec;
      return mk(REQ_DRAW, sr, sc, er, ec);
   endfunction

   // Aim a read or erase at the last line's ends, somewhere on the canvas, or anywhere.
   function automatic void aim_cell(inout req_type q);
      int s;
      s = $urandom_range(9, 0);
      if (s < 2) begin
         q.first_row = COORD_W'(last_sr);
         q.first_col = COORD_W'(last_sc);
      end else if (s < 4) begin
         q.first_row = COORD_W'(last_er);
         q.first_col = COORD_W'(last_ec);
      end else if (s < 9) begin
         q.first_row = COORD_W'(pick(rows_eff));
         q.first_col = COORD_W'(pick(cols_eff));
      end
   endfunction

   function automatic req_type make_item();
      logic [$bits(req_type)-1:0] raw;
      req_type q;
      int      p;
      raw = $bits(req_type)'($urandom());
      q = req_type'(raw);
      p = $urandom_range(99, 0);
      if (p < 50) begin
         q = make_line();
      end else if (p < 60) begin
         q.req_type = REQ_DRAW;
      end else if (p < 78) begin
         q.req_type = REQ_READ;
         aim_cell(q);
      end else if (p < 92) begin
         q.req_type = REQ_ERASE;
         aim_cell(q);
      end else if (p < 94) begin
         q.req_type = REQ_CLEAR;
      end
      // clears cost a full memory sweep: keep them few
      if (q.req_type == REQ_CLEAR) begin
         if (clears_left > 0) clears_left--;
         else q.req_type = REQ_READ;
      end
      return q;
   endfunction

   task automatic send(req_type item, bit allow_idle);
      int gap;
      gap = 0;
      if (allow_idle) begin
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(40, 8);
            idle_on = 1'($urandom_range(1, 0));
         end
         stretch_left--;
         if (idle_on && $urandom_range(2, 0) == 0) gap = $urandom_range(11, 1);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (busy);
      sent++;
      if (item.req_type == REQ_CLEAR) clears_sent++;
   endtask

   // Hold off until every expected result is back.
   task automatic drain();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_canvas(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_we <= 1'b0;
      rows_eff = (rows == 0) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
      cols_eff = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
      settings_used++;
      @(posedge clock);
   endtask

   initial begin
      int ph, i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // full 64x64 canvas: every direction, crossings, rejects and a clear
      send(mk(REQ_READ, 0, 0, 0, 0), 1'b1);
      send(mk(REQ_DRAW, 0, 0, 0, 63), 1'b1);
      send(mk(REQ_DRAW, 0, 5, 63, 5), 1'b1);
      send(mk(REQ_DRAW, 0, 0, 63, 63), 1'b1);
      send(mk(REQ_DRAW, 63, 0, 0, 63), 1'b1);
      send(mk(REQ_DRAW, 0, 63, 0, 10), 1'b1);
      send(mk(REQ_DRAW, 3, 3, 3, 3), 1'b1);
      send(mk(REQ_DRAW, 0, 0, 1, 2), 1'b1);
      send(mk(REQ_DRAW, 10, 20, 20, 10), 1'b1);
      send(mk(REQ_READ, 0, 5, 0, 0), 1'b1);
      send(mk(REQ_READ, 0, 30, 0, 0), 1'b1);
      send(mk(REQ_READ, 63, 63, 63, 63), 1'b1);
      send(mk(REQ_READ, 58, 5, 0, 0), 1'b1);
      send(mk(REQ_READ, 32, 31, 0, 0), 1'b1);
      send(mk(REQ_ERASE, 0, 5, 63, 63), 1'b1);
      send(mk(REQ_READ, 0, 5, 0, 0), 1'b1);
      send(mk(REQ_CLEAR, 63, 63, 63, 63), 1'b1);
      send(mk(REQ_READ, 0, 30, 0, 0), 1'b1);

      // small canvas: bounds checks on draw, read and erase
      drain();
      set_canvas(DIM_W'(10), DIM_W'(20));
      send(mk(REQ_DRAW, 0, 0, 0, 25), 1'b1);
      send(mk(REQ_DRAW, 9, 19, 0, 10), 1'b1);
      send(mk(REQ_READ, 9, 19, 0, 0), 1'b1);
      send(mk(REQ_READ, 0, 20, 0, 0), 1'b1);
      send(mk(REQ_ERASE, 10, 0, 0, 0), 1'b1);
      send(mk(REQ_READ, 9, 0, 0, 0), 1'b1);

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: set_canvas(DIM_W'(64), DIM_W'(64));
            1: set_canvas(DIM_W'(0), DIM_W'(127));
            2: set_canvas(DIM_W'(1), DIM_W'(1));
            3: set_canvas(DIM_W'(127), DIM_W'(0));
            4: set_canvas(DIM_W'(65), DIM_W'(64));
            5: set_canvas(DIM_W'(64), DIM_W'(1));
            6: set_canvas(DIM_W'(3), DIM_W'(64));
            default: set_canvas(DIM_W'($urandom_range(127, 0)), DIM_W'($urandom_range(64, 1)));
         endcase
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (ph == 4 && i == ITEMS_PER_PHASE / 2) drain();
            send(make_item(), ph != PHASES - 1);
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb_top: %0d requests sent (%0d clears) over %0d canvas settings",
               sent, clears_sent, settings_used);
      $display("tb_top: %0d results checked; lines in four directions with crossings,",
               checked);
      $display("tb_top: rejects, ignores, erase and read");
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ccld_pkg.sv
rtl/ccld_decode.sv
rtl/char_canvas_line_drawer_top.sv
tb/canvas_checker.sv
tb/tb_top.sv
